// ----- src/shrw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package shrw_pkg;

    localparam int RING_DEPTH     = 256;
    localparam int SNAPSHOT_LIMIT = 32;

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CNT_W  = $clog2(SNAPSHOT_LIMIT + 1);
    localparam int SIZE_W = 6;
    localparam int TIME_W = 64;
    localparam int WORD_W = 32;

    localparam logic [TIME_W-1:0] MS_HOUR = 64'd3600000;
    localparam logic [TIME_W-1:0] MS_DAY  = 64'd86400000;
    localparam logic [TIME_W-1:0] MS_WEEK = 64'd604800000;

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] WIN_DAY  = 2'd1;
    localparam logic [1:0] WIN_WEEK = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] time_ms;
        logic [WORD_W-1:0] voltage_word;
        logic [WORD_W-1:0] current_word;
        logic [WORD_W-1:0] temperature_word;
        logic [WORD_W-1:0] charge_word;
        logic [1:0]        window_sel;
    } sample_in_t;

    typedef struct packed {
        logic              sample_valid;
        logic [TIME_W-1:0] out_time_ms;
        logic [WORD_W-1:0] out_voltage;
        logic [WORD_W-1:0] out_current;
        logic [WORD_W-1:0] out_temperature;
        logic [WORD_W-1:0] out_charge;
        logic [SIZE_W-1:0] snapshot_size;
        logic [1:0]        window_echo;
        logic              last_of_run;
    } sample_out_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [WORD_W-1:0] voltage;
        logic [WORD_W-1:0] current;
        logic [WORD_W-1:0] temperature;
        logic [WORD_W-1:0] charge;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } sub_op_t;

    typedef struct packed {
        logic [TIME_W-1:0] diff;
        logic              borrow;
    } sub_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EMIT_RD,
        ST_EMIT_CAP,
        ST_OUT
    } state_t;

    function automatic logic [TIME_W-1:0] window_len(input logic [1:0] sel);
        logic [TIME_W-1:0] len;
        case (sel)
            WIN_DAY:  len = MS_DAY;
            WIN_WEEK: len = MS_WEEK;
            default:  len = MS_HOUR;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- src/shrw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shrw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/shrw_sub.sv -----
`timescale 1ns / 1ps
`default_nettype none

// shared 64-bit subtractor: cutoff = now - window, and timestamp >= cutoff via borrow
module shrw_sub
    import shrw_pkg::*;
(
    input  wire sub_op_t  op,
    output sub_res_t      res
);

    logic [TIME_W:0] wide;

    always_comb
    begin
        wide       = {1'b0, op.a} - {1'b0, op.b};
        res.diff   = wide[TIME_W-1:0];
        res.borrow = wide[TIME_W];
    end

endmodule

`default_nettype wire

// ----- src/sample_history_ring_window.sv -----
`timescale 1ns / 1ps
`default_nettype none

// ring of timestamped battery samples with time-window readback
//
// input channel (in_valid/in_ready/in_data): a push transaction (mode 0) stores a
// sample at the write pointer, overwriting the oldest one once the ring is full;
// it yields no result, so pushes can stream one per cycle while no query is pending.
// a query transaction (mode 1) carries the current time and a window selector.
// output channel (out_valid/out_ready/out_data): the samples of the window, oldest
// first, last_of_run on the final one; an empty window gives one result with
// sample_valid low.
// query steps: the cutoff is formed in the accept cycle; the walk back reads
// and compares each matching sample (at most SNAPSHOT_LIMIT) in SCAN_RD/SCAN_CMP,
// ending on a sample outside the window, or in SCAN_RD when the fill level or the
// limit ends it; each result is fetched through the single read port before it is
// offered. in_ready stays low from query acceptance until the last result is taken.
// a stalled receiver simply holds the current result in the output register.
// reset empties the ring (pointer and fill level to zero); memory contents are
// not cleared and need no clearing pass.
module sample_history_ring_window
    import shrw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire sample_in_t  in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output sample_out_t      out_data
);

    state_t state_reg, state_next;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  oldest_reg, oldest_next;
    logic [FILL_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0] cutoff_reg, cutoff_next;
    logic [1:0]        sel_reg, sel_next;
    sample_out_t       out_reg, out_next;

    logic              wr_en;
    entry_t            wr_entry;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [$bits(entry_t)-1:0] rd_raw;
    entry_t            rd_entry;

    sub_op_t           sub_op;
    sub_res_t          sub_res;

    logic              in_fire;
    logic              scan_end;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - 1'b1;
    endfunction

    shrw_ram #(
        .DATA_W ($bits(entry_t)),
        .DEPTH  (RING_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_entry = entry_t'(rd_raw);

    shrw_sub u_sub (
        .op  (sub_op),
        .res (sub_res)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = out_reg;

    always_comb
    begin
        wr_entry.time_ms     = in_data.time_ms;
        wr_entry.voltage     = in_data.voltage_word;
        wr_entry.current     = in_data.current_word;
        wr_entry.temperature = in_data.temperature_word;
        wr_entry.charge      = in_data.charge_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        oldest_reg <= oldest_next;
        step_reg   <= step_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        cutoff_reg <= cutoff_next;
        sel_reg    <= sel_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        oldest_next = oldest_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        cutoff_next = cutoff_reg;
        sel_next    = sel_reg;
        out_next    = out_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg;
        scan_end    = 1'b0;
        sub_op.a    = rd_entry.time_ms;
        sub_op.b    = cutoff_reg;

        case (state_reg)
            ST_IDLE:
            begin
                sub_op.a = in_data.time_ms;
                sub_op.b = window_len(in_data.window_sel);
                if (in_fire)
                begin
                    if (in_data.mode == MODE_PUSH)
                    begin
                        wr_en   = 1'b1;
                        wp_next = ptr_inc(wp_reg);
                        if (fill_reg != FILL_W'(RING_DEPTH))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // clamp cutoff to zero when the window reaches before time zero
                        cutoff_next = sub_res.borrow ? '0 : sub_res.diff;
                        sel_next    = in_data.window_sel;
                        ptr_next    = ptr_dec(wp_reg);
                        step_next   = '0;
                        cnt_next    = '0;
                        state_next  = ST_SCAN_RD;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                if ((step_reg < fill_reg) && (cnt_reg < CNT_W'(SNAPSHOT_LIMIT)))
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
                else
                begin
                    scan_end = 1'b1;
                end
            end

            ST_SCAN_CMP:
            begin
                if (!sub_res.borrow)
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    step_next   = step_reg + 1'b1;
                    oldest_next = ptr_reg;
                    ptr_next    = ptr_dec(ptr_reg);
                    state_next  = ST_SCAN_RD;
                end
                else
                begin
                    scan_end = 1'b1;
                end
            end

            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_EMIT_CAP;
            end

            ST_EMIT_CAP:
            begin
                out_next.sample_valid    = 1'b1;
                out_next.out_time_ms     = rd_entry.time_ms;
                out_next.out_voltage     = rd_entry.voltage;
                out_next.out_current     = rd_entry.current;
                out_next.out_temperature = rd_entry.temperature;
                out_next.out_charge      = rd_entry.charge;
                out_next.snapshot_size   = SIZE_W'(cnt_reg);
                out_next.window_echo     = sel_reg;
                out_next.last_of_run     = (rem_reg == CNT_W'(1));
                state_next               = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (out_reg.last_of_run)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rem_next   = rem_reg - 1'b1;
                        ptr_next   = ptr_inc(ptr_reg);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (scan_end)
        begin
            if (cnt_reg == '0)
            begin
                out_next               = '0;
                out_next.window_echo   = sel_reg;
                out_next.last_of_run   = 1'b1;
                state_next             = ST_OUT;
            end
            else
            begin
                rem_next   = cnt_reg;
                ptr_next   = oldest_reg;
                state_next = ST_EMIT_RD;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/shrw_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shrw_chk
    import shrw_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire sample_in_t  in_data,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire sample_out_t out_data
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input side is closed while any result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during readback");

    // a query closes the input side on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.mode == MODE_QUERY |=> !in_ready)
        else $error("input ready right after query");

    // taking the final result reopens the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_of_run |=> in_ready && !out_valid)
        else $error("block not idle after last result");

    // empty snapshot is a single zeroed result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sample_valid |->
            out_data.last_of_run && out_data.snapshot_size == '0
            && out_data.out_time_ms == '0)
        else $error("malformed empty snapshot");

endmodule

bind sample_history_ring_window shrw_chk u_shrw_chk (.*);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import shrw_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLD_AT       = 150;
    localparam int PAUSE_AT      = 320;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DIRECTED_ROWS = 19;
    localparam int NOISE_PCT     = 5;
    localparam int QUERY_PCT     = 20;

    localparam logic [1:0]        WIN_HOUR     = 2'd0;
    localparam logic [1:0]        WIN_HOUR_ALT = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX     = '1;
    localparam logic [WORD_W-1:0] WORD_ONES    = '1;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

    typedef struct {
        sample_in_t  item;
        bit          typed;
        sample_out_t result;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    sample_in_t  in_data;
    logic        out_valid;
    logic        out_ready;
    sample_out_t out_data;

    entry_t      history[RING_DEPTH];
    int unsigned history_head;
    int unsigned history_fill;
    sample_out_t snapshot_due[$];
    int          mismatch_count = 0;
    bit          long_hold_req;
    int          cycle_count;

    sample_history_ring_window uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic logic [TIME_W-1:0] span_ms(input logic [1:0] sel);
        if (sel == WIN_DAY)
            return MS_DAY;
        else if (sel == WIN_WEEK)
            return MS_WEEK;
        return MS_HOUR;
    endfunction

    function automatic sample_in_t mk_push(input logic [TIME_W-1:0] t,
                                           input logic [WORD_W-1:0] v, c, tmp, q);
        sample_in_t item;
        item.mode             = MODE_PUSH;
        item.time_ms          = t;
        item.voltage_word     = v;
        item.current_word     = c;
        item.temperature_word = tmp;
        item.charge_word      = q;
        item.window_sel       = WIN_HOUR_ALT;
        return item;
    endfunction

    function automatic sample_in_t mk_query(input logic [TIME_W-1:0] t, input logic [1:0] sel,
                                            input logic [WORD_W-1:0] filler);
        sample_in_t item;
        item.mode             = MODE_QUERY;
        item.time_ms          = t;
        item.voltage_word     = filler;
        item.current_word     = filler;
        item.temperature_word = filler;
        item.charge_word      = filler;
        item.window_sel       = sel;
        return item;
    endfunction

    function automatic sample_out_t empty_result(input logic [1:0] sel);
        sample_out_t r;
        r             = '0;
        r.window_echo = sel;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    // store a pushed sample, or work out the snapshot of a query
    function automatic void advance_history(input sample_in_t item, input bit enqueue);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] cutoff;
        int unsigned       slot;
        int unsigned       found;
        int unsigned       picked[SNAPSHOT_LIMIT];
        sample_out_t       res;
        if (item.mode == MODE_PUSH)
        begin
            history[history_head] = '{item.time_ms, item.voltage_word, item.current_word,
                                      item.temperature_word, item.charge_word};
            history_head = (history_head + 1) % RING_DEPTH;
            if (history_fill < RING_DEPTH)
                history_fill++;
            return;
        end
        span   = span_ms(item.window_sel);
        cutoff = (item.time_ms >= span) ? item.time_ms - span : '0;
        found  = 0;
        // newest first, stop at the first sample older than the cutoff
        for (int unsigned k = 0; k < history_fill && found < SNAPSHOT_LIMIT; k++)
        begin
            slot = (history_head + RING_DEPTH - 1 - k) % RING_DEPTH;
            if (history[slot].time_ms < cutoff)
                break;
            picked[found] = slot;
            found++;
        end
        if (!enqueue)
            return;
        if (found == 0)
        begin
            snapshot_due.insert(snapshot_due.size(), empty_result(item.window_sel));
            return;
        end
        for (int k = int'(found) - 1; k >= 0; k--)
        begin
            res.sample_valid    = 1'b1;
            res.out_time_ms     = history[picked[k]].time_ms;
            res.out_voltage     = history[picked[k]].voltage;
            res.out_current     = history[picked[k]].current;
            res.out_temperature = history[picked[k]].temperature;
            res.out_charge      = history[picked[k]].charge;
            res.snapshot_size   = SIZE_W'(found);
            res.window_echo     = item.window_sel;
            res.last_of_run     = (k == 0);
            snapshot_due.insert(snapshot_due.size(), res);
        end
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic offer(input sample_in_t item, input bit typed, input sample_out_t result);
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        advance_history(item, !typed);
        if (typed)
            snapshot_due.insert(snapshot_due.size(), result);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        sample_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (snapshot_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = snapshot_due.pop_front();
                compare_field("sample_valid", want.sample_valid, out_data.sample_valid);
                compare_field("out_time_ms", want.out_time_ms, out_data.out_time_ms);
                compare_field("out_voltage", want.out_voltage, out_data.out_voltage);
                compare_field("out_current", want.out_current, out_data.out_current);
                compare_field("out_temperature", want.out_temperature,
                              out_data.out_temperature);
                compare_field("out_charge", want.out_charge, out_data.out_charge);
                compare_field("snapshot_size", want.snapshot_size, out_data.snapshot_size);
                compare_field("window_echo", want.window_echo, out_data.window_echo);
                compare_field("last_of_run", want.last_of_run, out_data.last_of_run);
            end
        end
    end

    initial
    begin : receiver
        int        phase_cycles;
        rx_style_t style;
        bit        hold_done;
        phase_cycles = 0;
        style        = RX_OPEN;
        hold_done    = 1'b0;
        out_ready    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (phase_cycles == 0)
                begin
                    style        = rx_style_t'($urandom_range(0, 3));
                    phase_cycles = $urandom_range(20, 120);
                end
                phase_cycles--;
                case (style)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= ~out_ready;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sample_history_ring_window: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        directed_row_t     directed[DIRECTED_ROWS];
        sample_in_t        item;
        logic [TIME_W-1:0] base_ms;
        int unsigned       step_max;
        int unsigned       spacing_choices[5];
        int unsigned       offset_choices[4];
        int                burst_left;
        int                gap;
        int                pick;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        long_hold_req  = 1'b0;
        history_head   = 0;
        history_fill   = 0;

        spacing_choices = '{1, 1000, 200000, 2000000, 50000000};
        offset_choices  = '{0, MS_HOUR[31:0], MS_DAY[31:0], 2 * MS_WEEK[31:0]};

        // empty ring, window extremes, clamped cutoffs, exact cutoff boundary
        directed[0]  = '{mk_query('0, WIN_HOUR, '0), 1'b1, empty_result(WIN_HOUR)};
        directed[1]  = '{mk_query(TIME_MAX, WIN_HOUR_ALT, WORD_ONES), 1'b1,
                         empty_result(WIN_HOUR_ALT)};
        directed[2]  = '{mk_push('0, '0, '0, '0, '0), 1'b0, '0};
        directed[3]  = '{mk_push(64'd1000, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES),
                         1'b0, '0};
        directed[4]  = '{mk_query('0, WIN_DAY, '0), 1'b0, '0};
        directed[5]  = '{mk_push(TIME_MAX, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h0000FFFF,
                                 32'hFFFF0000), 1'b0, '0};
        directed[6]  = '{mk_query(TIME_MAX, WIN_WEEK, '0), 1'b0, '0};
        directed[7]  = '{mk_query(TIME_MAX, WIN_HOUR, WORD_ONES), 1'b0, '0};
        directed[8]  = '{mk_query(MS_HOUR - 1, WIN_HOUR_ALT, '0), 1'b0, '0};
        directed[9]  = '{mk_query(MS_HOUR, WIN_HOUR, '0), 1'b0, '0};
        directed[10] = '{mk_push(64'd10, 32'd1, 32'd2, 32'd3, 32'd4), 1'b0, '0};
        directed[11] = '{mk_query(TIME_MAX, WIN_DAY, '0), 1'b1, empty_result(WIN_DAY)};
        directed[12] = '{mk_push(64'd5000000, 32'h80000000, 32'h7FFFFFFF, 32'h00000001,
                                 32'hFFFFFFFE), 1'b0, '0};
        directed[13] = '{mk_query(64'd5000000 + MS_HOUR, WIN_HOUR_ALT, '0), 1'b0, '0};
        directed[14] = '{mk_query(64'd5000000 + MS_HOUR + 1, WIN_HOUR, '0), 1'b1,
                         empty_result(WIN_HOUR)};
        directed[15] = '{mk_push(MS_WEEK, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
                                 32'hF0F0F0F0), 1'b0, '0};
        directed[16] = '{mk_query(MS_WEEK + MS_WEEK, WIN_WEEK, '0), 1'b0, '0};
        directed[17] = '{mk_query(MS_WEEK + MS_DAY, WIN_DAY, '0), 1'b0, '0};
        directed[18] = '{mk_query(MS_WEEK - 1, WIN_WEEK, '0), 1'b0, '0};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[r])
            offer(directed[r].item, directed[r].typed, directed[r].result);

        // mostly rising timestamps at varying spacing so windows catch a few to many samples
        base_ms    = 64'($urandom_range(0, 20000000));
        step_max   = 1000;
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                step_max   = spacing_choices[$urandom_range(0, 4)];
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (n == HOLD_AT)
            begin
                // receiver stalls while a query is in flight and the next item waits at the input
                long_hold_req = 1'b1;
                pick          = NOISE_PCT;
            end
            if (n == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                do @(negedge clk); while (snapshot_due.size() != 0);
            end
            if (pick < NOISE_PCT)
            begin
                item.mode             = 1'($urandom_range(0, 1));
                item.time_ms          = {$urandom(), $urandom()};
                item.voltage_word     = $urandom();
                item.current_word     = $urandom();
                item.temperature_word = $urandom();
                item.charge_word      = $urandom();
                item.window_sel       = 2'($urandom_range(0, 3));
            end
            else if (pick < NOISE_PCT + QUERY_PCT)
            begin
                item = mk_query(base_ms + 64'($urandom_range(0,
                                    offset_choices[$urandom_range(0, 3)])),
                                2'($urandom_range(0, 3)), $urandom());
            end
            else
            begin
                base_ms         = base_ms + 64'($urandom_range(0, step_max));
                item            = mk_push(base_ms, $urandom(), $urandom(), $urandom(),
                                          $urandom());
                item.window_sel = 2'($urandom_range(0, 3));
            end
            offer(item, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (snapshot_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("sample_history_ring_window: match");
        else
            $display("sample_history_ring_window: mismatch");
        $finish;
    end

endmodule
